// ===== src/fbsa_pkg.sv =====
package fbsa_pkg;

  // Fixed field widths of the block's ports
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int COUNT_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

  typedef enum logic [1:0] {
    FUNC_INIT  = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_BADADDR = 2'd3
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    take_item;
    logic    init_counts;
    logic    drop_list;
    logic    build_begin;
    logic    build_step;
    logic    alloc_read;
    logic    alloc_commit;
    logic    div_start;
    logic    free_commit;
    logic    set_result;
    status_t result;
    logic    out_load;
  } fbsa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    func_t func;
    logic  settings_ok;
    logic  built;
    logic  build_last;
    logic  no_block;
    logic  free_pre_bad;
    logic  free_post_bad;
    logic  div_done;
    logic  out_room;
  } fbsa_sts_t;

endpackage

// ===== src/fixed_block_slab_allocator.sv =====
// Fixed-size block allocator over a buffer of equal blocks described by three
// configuration registers: buffer base (index 0), block size in bytes
// (index 1) and block count (index 2). Send one word per operation on the input channel:
// func 0 initializes (checks the settings, builds the free list with block 0
// at the head, clears the used and peak counts), func 1 allocates the head
// block and returns its address, func 2 frees the block at block_address.
// An allocate or free before any successful initialize builds the list first.
// Every operation returns exactly one word with status, granted_address
// (zero unless an allocate succeeds), blocks_used and peak_used. The block
// handles one operation at a time. A free that passes its first checks runs the
// address-to-index division, one quotient bit per cycle, before its index
// check; an initialize builds the list one link entry per cycle through the
// single write port of the link memory, and a lazy build does the same ahead
// of the first allocate or free. A finished result waits in the output
// register without blocking the next operation's work. Write configuration
// only while no operation is in flight. Link memory entries are undefined
// after reset; no clearing pass is run.
module fixed_block_slab_allocator #(
  parameter int BLOCK_CAPACITY = 256,
  parameter int ADDRESS_WIDTH  = 32,
  parameter int WORD_BYTES     = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            write_enable,
  input  logic [fbsa_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [fbsa_pkg::CFG_DATA_W-1:0] write_data,
  // Operation channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      func,
  input  logic [fbsa_pkg::ADDR_W-1:0]     block_address,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [fbsa_pkg::ADDR_W-1:0]     granted_address,
  output logic [fbsa_pkg::COUNT_W-1:0]    blocks_used,
  output logic [fbsa_pkg::COUNT_W-1:0]    peak_used
);
  import fbsa_pkg::*;

  // Controller drives the datapath through commands and watches its status
  fbsa_cmd_t cmd;
  fbsa_sts_t sts;

  // Sequence each operation: dispatch, optional list build, then the
  // allocate or free steps, then hand the word to the output register.
  fbsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the configuration, the free list and its link memory, the counts,
  // the divider and the output register.
  fbsa_datapath #(
    .BLOCK_CAPACITY (BLOCK_CAPACITY),
    .ADDRESS_WIDTH  (ADDRESS_WIDTH),
    .WORD_BYTES     (WORD_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .write_enable    (write_enable),
    .write_index     (write_index),
    .write_data      (write_data),
    .func            (func),
    .block_address   (block_address),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .status          (status),
    .granted_address (granted_address),
    .blocks_used     (blocks_used),
    .peak_used       (peak_used)
  );

endmodule

// ===== src/fbsa_divider.sv =====
module fbsa_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fbsa_pkg::ADDR_W-1:0] dividend,
  input  logic [fbsa_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [fbsa_pkg::ADDR_W-1:0] quotient,
  output logic [fbsa_pkg::SIZE_W-1:0] remainder
);
  import fbsa_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W);

  logic              busy;
  logic [STEP_W-1:0] step_cnt;
  logic [SIZE_W-1:0] dsor;
  logic [ADDR_W-1:0] quo;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W:0]   trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem, quo[ADDR_W-1]};
  assign fits  = trial >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= STEP_W'(ADDR_W - 1);
        dsor     <= divisor;
        quo      <= dividend;
        rem      <= '0;
      end else if (busy) begin
        rem <= fits ? SIZE_W'(trial - {1'b0, dsor}) : trial[SIZE_W-1:0];
        quo <= {quo[ADDR_W-2:0], fits};
        if (step_cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step_cnt <= step_cnt - STEP_W'(1);
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== src/fbsa_datapath.sv =====
module fbsa_datapath #(
  parameter int BLOCK_CAPACITY = 256,
  parameter int ADDRESS_WIDTH  = 32,
  parameter int WORD_BYTES     = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [fbsa_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [fbsa_pkg::CFG_DATA_W-1:0] write_data,
  input  logic [1:0]                      func,
  input  logic [fbsa_pkg::ADDR_W-1:0]     block_address,
  input  logic                            out_ready,
  input  fbsa_pkg::fbsa_cmd_t             cmd,
  output fbsa_pkg::fbsa_sts_t             sts,
  output logic                            out_valid,
  output logic [1:0]                      status,
  output logic [fbsa_pkg::ADDR_W-1:0]     granted_address,
  output logic [fbsa_pkg::COUNT_W-1:0]    blocks_used,
  output logic [fbsa_pkg::COUNT_W-1:0]    peak_used
);
  import fbsa_pkg::*;

  localparam int IDX_W  = (BLOCK_CAPACITY > 1) ? $clog2(BLOCK_CAPACITY) : 1;
  localparam int LINK_W = $clog2(BLOCK_CAPACITY + 1);
  localparam int CMP_W  = (LINK_W > COUNT_W) ? LINK_W : COUNT_W;
  localparam int SUM_W  = ADDR_W + 1;
  localparam int SPROD_W = SIZE_W + COUNT_W;
  localparam int GPROD_W = SIZE_W + IDX_W;

  localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(BLOCK_CAPACITY);
  localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(WORD_BYTES - 1);
  localparam logic [SUM_W-1:0]  SUM_ONE    = SUM_W'(1);
  localparam logic [ADDR_W-1:0] ADDR_ONE   = ADDR_W'(1);
  localparam logic [SUM_W-1:0]  OVER_MASK  = (ADDRESS_WIDTH >= SUM_W) ? '0 :
                                             ~((SUM_ONE << ADDRESS_WIDTH) - SUM_ONE);
  localparam logic [ADDR_W-1:0] GRANT_MASK = (ADDRESS_WIDTH >= ADDR_W) ? '1 :
                                             ((ADDR_ONE << ADDRESS_WIDTH) - ADDR_ONE);

  // Configuration registers
  logic [ADDR_W-1:0]  buffer_base;
  logic [SIZE_W-1:0]  blk_bytes;
  logic [COUNT_W-1:0] block_count;

  // Allocator state
  logic [LINK_W-1:0]  link_mem [BLOCK_CAPACITY];
  logic [LINK_W-1:0]  free_head;
  logic [COUNT_W-1:0] used_count;
  logic [COUNT_W-1:0] peak_count;
  logic [COUNT_W-1:0] free_count;
  logic               list_built;

  // Working registers
  func_t              func_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [IDX_W-1:0]   build_cnt;
  logic [LINK_W-1:0]  link_rd;
  logic [SPROD_W-1:0] set_prod;
  logic [GPROD_W-1:0] grant_prod;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_granted;

  logic [SUM_W-1:0]   span_end;
  logic               settings_ok;
  logic               build_last;
  logic [LINK_W-1:0]  build_link;
  logic [IDX_W-1:0]   head_idx;
  logic [ADDR_W-1:0]  grant_addr;
  logic [COUNT_W-1:0] used_next;
  logic [ADDR_W-1:0]  offset;
  logic               div_done;
  logic [ADDR_W-1:0]  div_quot;
  logic [SIZE_W-1:0]  div_rem;
  logic [IDX_W-1:0]   free_idx;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [LINK_W-1:0]  wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base <= '0;
      blk_bytes   <= '0;
      block_count <= '0;
    end else if (write_enable) begin
      unique case (write_index)
        REG_BUFFER_BASE: buffer_base <= write_data;
        REG_BLOCK_SIZE:  blk_bytes   <= write_data[SIZE_W-1:0];
        REG_BLOCK_COUNT: block_count <= write_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Buffer span product, registered ahead of the check
  always_ff @(posedge clk) begin
    set_prod <= blk_bytes * block_count;
  end

  assign span_end    = SUM_W'(buffer_base) + SUM_W'(set_prod);
  assign settings_ok = (blk_bytes != '0) && (block_count != '0) &&
                       (((blk_bytes | buffer_base[SIZE_W-1:0]) & ALIGN_MASK) == '0) &&
                       (32'(block_count) <= 32'(BLOCK_CAPACITY)) &&
                       ((span_end & OVER_MASK) == '0);

  assign build_last = (CMP_W'(build_cnt) + CMP_W'(1)) == CMP_W'(block_count);
  assign build_link = build_last ? NULL_LINK : LINK_W'(build_cnt) + LINK_W'(1);
  assign head_idx   = free_head[IDX_W-1:0];
  assign grant_addr = (buffer_base + ADDR_W'(grant_prod)) & GRANT_MASK;
  assign used_next  = used_count + COUNT_W'(1);
  assign offset     = addr_q - buffer_base;
  assign free_idx   = div_quot[IDX_W-1:0];

  fbsa_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (offset),
    .divisor   (blk_bytes),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Link memory: one write port shared by build and free, one registered read
  assign wr_en   = cmd.build_step | cmd.free_commit;
  assign wr_addr = cmd.build_step ? build_cnt : free_idx;
  assign wr_data = cmd.build_step ? build_link : free_head;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.alloc_read) begin
      link_rd <= link_mem[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      func_q      <= func_t'(func);
      addr_q      <= block_address;
      res_granted <= '0;
    end
    if (cmd.build_begin) begin
      build_cnt <= '0;
    end else if (cmd.build_step) begin
      build_cnt <= build_cnt + IDX_W'(1);
    end
    if (cmd.alloc_read) begin
      grant_prod <= head_idx * blk_bytes;
    end
    if (cmd.alloc_commit) begin
      res_granted <= grant_addr;
    end
    if (cmd.set_result) begin
      res_status <= cmd.result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= NULL_LINK;
      used_count <= '0;
      peak_count <= '0;
      free_count <= '0;
      list_built <= 1'b0;
    end else begin
      if (cmd.init_counts) begin
        used_count <= '0;
        peak_count <= '0;
      end
      if (cmd.drop_list) begin
        list_built <= 1'b0;
        free_head  <= NULL_LINK;
        free_count <= '0;
      end
      if (cmd.build_step && build_last) begin
        free_head  <= '0;
        free_count <= block_count;
        list_built <= 1'b1;
      end
      if (cmd.alloc_commit) begin
        free_head  <= link_rd;
        free_count <= free_count - COUNT_W'(1);
        used_count <= used_next;
        if (used_next > peak_count) begin
          peak_count <= used_next;
        end
      end
      if (cmd.free_commit) begin
        free_head  <= LINK_W'(free_idx);
        free_count <= free_count + COUNT_W'(1);
        used_count <= used_count - COUNT_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status          <= res_status;
      granted_address <= res_granted;
      blocks_used     <= used_count;
      peak_used       <= peak_count;
    end
  end

  always_comb begin
    sts.func          = func_q;
    sts.settings_ok   = settings_ok;
    sts.built         = list_built;
    sts.build_last    = build_last;
    sts.no_block      = (free_count == '0) || (free_head >= NULL_LINK);
    sts.free_pre_bad  = (used_count == '0) || (blk_bytes == '0) || (addr_q < buffer_base);
    sts.free_post_bad = (div_rem != '0) || (div_quot >= ADDR_W'(block_count)) ||
                        (div_quot >= ADDR_W'(BLOCK_CAPACITY));
    sts.div_done      = div_done;
    sts.out_room      = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (32'(used_count) + 32'(free_count)) <= 32'(BLOCK_CAPACITY))
    else $error("used plus free blocks exceed capacity");

  a_peak_covers_used: assert property (@(posedge clk) disable iff (rst)
    peak_count >= used_count)
    else $error("peak count below used count");

  a_alloc_has_block: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_commit |-> (free_count != '0) && (free_head < NULL_LINK))
    else $error("allocation committed with an empty free list");

  a_free_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.free_commit |-> (div_quot < ADDR_W'(BLOCK_CAPACITY)) && (used_count != '0))
    else $error("free committed with a bad index or no block in use");
`endif

endmodule

// ===== src/fbsa_ctrl.sv =====
module fbsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fbsa_pkg::fbsa_sts_t sts,
  output fbsa_pkg::fbsa_cmd_t cmd
);
  import fbsa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_DISPATCH   = 8'b0000_0010,
    S_BUILD      = 8'b0000_0100,
    S_OP         = 8'b0000_1000,
    S_ALLOC_WAIT = 8'b0001_0000,
    S_DIV        = 8'b0010_0000,
    S_FREE_CHK   = 8'b0100_0000,
    S_FINISH     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.result = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.func)
          FUNC_INIT: begin
            cmd.init_counts = 1'b1;
            if (sts.settings_ok) begin
              cmd.build_begin = 1'b1;
              state_next      = S_BUILD;
            end else begin
              cmd.drop_list  = 1'b1;
              cmd.set_result = 1'b1;
              cmd.result     = ST_INVALID;
              state_next     = S_FINISH;
            end
          end
          FUNC_ALLOC, FUNC_FREE: begin
            priority if (sts.built) begin
              state_next = S_OP;
            end else if (sts.settings_ok) begin
              cmd.build_begin = 1'b1;
              state_next      = S_BUILD;
            end else begin
              cmd.set_result = 1'b1;
              cmd.result     = ST_INVALID;
              state_next     = S_FINISH;
            end
          end
          default: begin
            cmd.set_result = 1'b1;
            cmd.result     = ST_INVALID;
            state_next     = S_FINISH;
          end
        endcase
      end
      S_BUILD: begin
        cmd.build_step = 1'b1;
        if (sts.build_last) begin
          if (sts.func == FUNC_INIT) begin
            cmd.set_result = 1'b1;
            cmd.result     = ST_OK;
            state_next     = S_FINISH;
          end else begin
            state_next = S_OP;
          end
        end
      end
      S_OP: begin
        if (sts.func == FUNC_ALLOC) begin
          if (sts.no_block) begin
            cmd.set_result = 1'b1;
            cmd.result     = ST_NOMEM;
            state_next     = S_FINISH;
          end else begin
            cmd.alloc_read = 1'b1;
            state_next     = S_ALLOC_WAIT;
          end
        end else begin
          if (sts.free_pre_bad) begin
            cmd.set_result = 1'b1;
            cmd.result     = ST_BADADDR;
            state_next     = S_FINISH;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end
      end
      S_ALLOC_WAIT: begin
        cmd.alloc_commit = 1'b1;
        cmd.set_result   = 1'b1;
        cmd.result       = ST_OK;
        state_next       = S_FINISH;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        cmd.set_result = 1'b1;
        if (sts.free_post_bad) begin
          cmd.result = ST_BADADDR;
        end else begin
          cmd.free_commit = 1'b1;
          cmd.result      = ST_OK;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_room) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== verif/fbsa_checker.sv =====
module fbsa_checker
  import fbsa_pkg::*;
#(
  parameter int BLOCK_CAPACITY = 256,
  parameter int WORD_BYTES     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic [CFG_IDX_W-1:0]  write_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [ADDR_W-1:0]     block_address,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            status,
  input  logic [ADDR_W-1:0]     granted_address,
  input  logic [COUNT_W-1:0]    blocks_used,
  input  logic [COUNT_W-1:0]    peak_used,
  output int                    mismatches,
  output int                    replies_owed
);

  localparam longint unsigned ADDR_TOP   = 64'hFFFF_FFFF;
  localparam int              REPORT_CAP = 40;

  typedef struct {
    status_t             status;
    logic [ADDR_W-1:0]   grant;
    logic [COUNT_W-1:0]  used;
    logic [COUNT_W-1:0]  peak;
  } slab_reply_t;

  // Allocator image: registers, link memory, list head and counters
  logic [ADDR_W-1:0]  cfg_base;
  logic [SIZE_W-1:0]  cfg_size;
  logic [COUNT_W-1:0] cfg_count;
  logic [COUNT_W-1:0] link_next [BLOCK_CAPACITY];
  logic [COUNT_W-1:0] head;
  int                 used_blocks;
  int                 peak_blocks;
  int                 free_left;
  bit                 list_ready;

  slab_reply_t slab_replies[$];
  int          tally = 0;

  function automatic void wipe_state();
    foreach (link_next[i]) link_next[i] = '0;
    head        = COUNT_W'(BLOCK_CAPACITY);
    used_blocks = 0;
    peak_blocks = 0;
    free_left   = 0;
    list_ready  = 1'b0;
    cfg_base    = '0;
    cfg_size    = '0;
    cfg_count   = '0;
  endfunction

  function automatic bit settings_ok();
    longint unsigned span;
    if (cfg_size == 0 || cfg_count == 0) return 1'b0;
    if (((ADDR_W'(cfg_size) | cfg_base) & ADDR_W'(WORD_BYTES - 1)) != 0) return 1'b0;
    if (cfg_count > BLOCK_CAPACITY) return 1'b0;
    span = cfg_size;
    span = span * cfg_count;
    return (span + cfg_base) <= ADDR_TOP;
  endfunction

  // Chain blocks 0..count-1 in order, last one points at the null marker
  function automatic void lay_out_list();
    for (int i = 0; i < int'(cfg_count); i++)
      link_next[i] = (i + 1 < int'(cfg_count)) ? COUNT_W'(i + 1) : COUNT_W'(BLOCK_CAPACITY);
    head       = '0;
    free_left  = cfg_count;
    list_ready = 1'b1;
  endfunction

  function automatic bit list_usable();
    if (list_ready) return 1'b1;
    if (!settings_ok()) return 1'b0;
    lay_out_list();
    return 1'b1;
  endfunction

  function automatic slab_reply_t run_slab_op(func_t op, logic [ADDR_W-1:0] addr);
    slab_reply_t     r;
    longint unsigned off;
    longint unsigned idx;
    r.status = ST_OK;
    r.grant  = '0;
    case (op)
      FUNC_INIT: begin
        used_blocks = 0;
        peak_blocks = 0;
        if (settings_ok()) begin
          lay_out_list();
        end else begin
          r.status   = ST_INVALID;
          list_ready = 1'b0;
          head       = COUNT_W'(BLOCK_CAPACITY);
          free_left  = 0;
        end
      end
      FUNC_ALLOC: begin
        if (!list_usable()) begin
          r.status = ST_INVALID;
        end else if (free_left == 0 || head >= BLOCK_CAPACITY) begin
          r.status = ST_NOMEM;
        end else begin
          r.grant = cfg_base + ADDR_W'(head) * ADDR_W'(cfg_size);
          head    = link_next[head];
          free_left--;
          used_blocks++;
          if (used_blocks > peak_blocks) peak_blocks = used_blocks;
        end
      end
      FUNC_FREE: begin
        if (!list_usable()) begin
          r.status = ST_INVALID;
        end else if (used_blocks == 0 || cfg_size == 0 || addr < cfg_base) begin
          r.status = ST_BADADDR;
        end else begin
          off = addr - cfg_base;
          idx = off / cfg_size;
          if (off % cfg_size != 0 || idx >= cfg_count || idx >= BLOCK_CAPACITY) begin
            r.status = ST_BADADDR;
          end else begin
            link_next[idx] = head;
            head           = COUNT_W'(idx);
            free_left++;
            used_blocks--;
          end
        end
      end
      default: r.status = ST_INVALID;
    endcase
    r.used = COUNT_W'(used_blocks);
    r.peak = COUNT_W'(peak_blocks);
    return r;
  endfunction

  function automatic void compare_field(string name, logic [ADDR_W-1:0] want,
                                        logic [ADDR_W-1:0] got);
    if (got !== want) begin
      tally++;
      if (tally <= REPORT_CAP)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    slab_reply_t want;
    if (rst) begin
      wipe_state();
      slab_replies.delete();
    end else begin
      if (write_enable) begin
        case (write_index)
          REG_BUFFER_BASE: cfg_base  = write_data[ADDR_W-1:0];
          REG_BLOCK_SIZE:  cfg_size  = write_data[SIZE_W-1:0];
          REG_BLOCK_COUNT: cfg_count = write_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        slab_replies.push_back(run_slab_op(func_t'(func), block_address));
      if (out_valid && out_ready) begin
        if (slab_replies.size() == 0) begin
          tally++;
          if (tally <= REPORT_CAP)
            $display("%0t: result word with none pending: status %0d granted %h used %0d peak %0d",
                     $time, status, granted_address, blocks_used, peak_used);
        end else begin
          want = slab_replies.pop_front();
          compare_field("status", ADDR_W'(want.status), ADDR_W'(status));
          compare_field("granted_address", want.grant, granted_address);
          compare_field("blocks_used", ADDR_W'(want.used), ADDR_W'(blocks_used));
          compare_field("peak_used", ADDR_W'(want.peak), ADDR_W'(peak_used));
        end
      end
    end
    mismatches   <= tally;
    replies_owed <= slab_replies.size();
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import fbsa_pkg::*;

  // Longest correct stretch without a handshake is a receiver hold-off
  // overlapping a full 256-block list build; leave plenty of margin.
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 300;
  localparam int RANDOM_OPS  = 1600;

  typedef enum logic [1:0] {
    RX_OPEN   = 2'd0,
    RX_MOSTLY = 2'd1,
    RX_SPARSE = 2'd2,
    RX_COIN   = 2'd3
  } rx_mode_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  write_enable  = 1'b0;
  logic [CFG_IDX_W-1:0]  write_index   = REG_BUFFER_BASE;
  logic [CFG_DATA_W-1:0] write_data    = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [1:0]            func          = FUNC_INIT;
  logic [ADDR_W-1:0]     block_address = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [1:0]            status;
  logic [ADDR_W-1:0]     granted_address;
  logic [COUNT_W-1:0]    blocks_used;
  logic [COUNT_W-1:0]    peak_used;

  int slab_errors;
  int replies_owed;

  // Settings currently loaded, used to aim free addresses
  logic [ADDR_W-1:0]  cur_base  = '0;
  logic [SIZE_W-1:0]  cur_size  = '0;
  logic [COUNT_W-1:0] cur_count = '0;

  // Addresses handed out and not yet freed, learned from the result channel
  logic [ADDR_W-1:0] held_blocks[$];
  logic [1:0]        sent_funcs[$];

  int       burst_left   = 0;
  int       holds_asked  = 0;
  int       holds_served = 0;
  int       hold_left    = 0;
  int       quiet_cycles = 0;
  bit [15:0] rx_tick     = '0;
  rx_mode_t rx_mode      = RX_OPEN;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fixed_block_slab_allocator u_dut (
    .clk             (clk),
    .rst             (rst),
    .write_enable    (write_enable),
    .write_index     (write_index),
    .write_data      (write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .block_address   (block_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_address (granted_address),
    .blocks_used     (blocks_used),
    .peak_used       (peak_used)
  );

  fbsa_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .write_enable    (write_enable),
    .write_index     (write_index),
    .write_data      (write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .block_address   (block_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_address (granted_address),
    .blocks_used     (blocks_used),
    .peak_used       (peak_used),
    .mismatches      (slab_errors),
    .replies_owed    (replies_owed)
  );

  // Receiver: switch stall pattern each time rx_tick[5:0] wraps to zero; a hold
  // request from the stimulus drops ready for a long stretch so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_tick[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      if (holds_served != holds_asked) begin
        holds_served <= holds_asked;
        hold_left    <= HOLD_CYCLES;
        out_ready    <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_ready <= (rx_tick[1:0] == 2'd0);
          default:   out_ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Track which blocks are out on loan: pair each result word with the
  // operation that caused it; an initialize returns every block at once.
  always @(posedge clk) begin : track_grants
    logic [1:0] done_func;
    if (rst) begin
      sent_funcs.delete();
      held_blocks.delete();
    end else begin
      if (in_valid && in_ready) sent_funcs.push_back(func);
      if (out_valid && out_ready && sent_funcs.size() != 0) begin
        done_func = sent_funcs.pop_front();
        if (done_func == FUNC_INIT)
          held_blocks.delete();
        else if (done_func == FUNC_ALLOC && status == ST_OK)
          held_blocks.push_back(granted_address);
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL fixed_block_slab_allocator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one operation word; open a new burst, possibly after a gap, when
  // the current one runs out. Valid stays high between back-to-back words.
  task automatic offer_op(input func_t op, input logic [ADDR_W-1:0] addr);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    func          <= op;
    block_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every result word has come back
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  // Load all three registers back to back; junk above the register width
  // must be dropped by the block.
  task automatic apply_settings(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                                input logic [COUNT_W-1:0] count);
    logic [31:0] junk;
    junk = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
    write_enable <= 1'b1;
    write_index  <= REG_BUFFER_BASE;
    write_data   <= base;
    @(posedge clk);
    write_index  <= REG_BLOCK_SIZE;
    write_data   <= {junk[15:0], size};
    @(posedge clk);
    write_index  <= REG_BLOCK_COUNT;
    write_data   <= {junk[31:9], count};
    @(posedge clk);
    write_enable <= 1'b0;
    cur_base  = base;
    cur_size  = size;
    cur_count = count;
  endtask

  // Choose a buffer layout: mostly small valid ones, some full-capacity,
  // the largest block size at the top of the address space, exact fits
  // and a share of invalid layouts of every kind.
  task automatic pick_settings(output logic [ADDR_W-1:0] base, output logic [SIZE_W-1:0] size,
                               output logic [COUNT_W-1:0] count, output bit bogus);
    int roll;
    roll  = $urandom_range(0, 19);
    bogus = 1'b0;
    base  = $urandom & 32'h7FFF_FFFC;
    size  = SIZE_W'(4 * $urandom_range(1, 64));
    count = COUNT_W'($urandom_range(1, 16));
    if (roll == 9 || roll == 10) begin
      size  = SIZE_W'(4 * $urandom_range(1, 16));
      count = COUNT_W'(256);
    end else if (roll == 11) begin
      base  = 32'hFF00_03FC;
      size  = 16'hFFFC;
      count = COUNT_W'(256);
    end else if (roll == 12 || roll == 13) begin
      bogus = 1'b1;
      case ($urandom_range(0, 5))
        0: size = '0;
        1: count = '0;
        2: count = COUNT_W'($urandom_range(257, 511));
        3: base = base | ADDR_W'($urandom_range(1, 3));
        4: size = size | SIZE_W'($urandom_range(1, 3));
        default: base = ADDR_W'(0) - ADDR_W'(size) * ADDR_W'(count);
      endcase
    end else if (roll == 14) begin
      base  = '0;
      size  = SIZE_W'(4);
      count = COUNT_W'(1);
    end else if (roll == 15 || roll == 16) begin
      size  = SIZE_W'(4 * $urandom_range(1, 1024));
      count = COUNT_W'($urandom_range(1, 256));
      base  = 32'hFFFF_FFFC - ADDR_W'(size) * ADDR_W'(count);
    end
  endtask

  // Mostly return a block that is really out on loan; otherwise aim near
  // the buffer: any block slot up to past the end, misaligned, below the base, or anywhere.
  function automatic logic [ADDR_W-1:0] free_target();
    logic [ADDR_W-1:0] pick;
    int                slot;
    if (held_blocks.size() != 0 && $urandom_range(0, 9) < 8) begin
      slot = $urandom_range(0, held_blocks.size() - 1);
      pick = held_blocks[slot];
      held_blocks.delete(slot);
      return pick;
    end
    case ($urandom_range(0, 3))
      0: return cur_base + $urandom_range(0, cur_count + 1) * cur_size;
      1: return cur_base + $urandom_range(0, cur_count) * cur_size + $urandom_range(1, 3);
      2: return cur_base - $urandom_range(1, 64);
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
    bit                 bogus;
    bit                 open_with_init;
    int                 random_ops;
    int                 phase_len;
    int                 alloc_pct;
    int                 roll;
    func_t              op;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still zero: lazy build fails, reserved code is rejected
    offer_op(FUNC_ALLOC, 32'h0);
    offer_op(FUNC_FREE, 32'hFFFF_FFFF);
    offer_op(FUNC_RSVD, 32'h5A5A_A5A5);

    // Three 16-byte blocks: lazy build on first allocate, run dry, then
    // free below the base, misaligned, past the end, and the same block twice
    settle();
    apply_settings(32'h1000, 16'd16, 9'd3);
    offer_op(FUNC_ALLOC, 32'hFFFF_0000);
    offer_op(FUNC_ALLOC, 32'h0);
    offer_op(FUNC_ALLOC, 32'h0);
    offer_op(FUNC_ALLOC, 32'h0);
    offer_op(FUNC_FREE, 32'h0FFC);
    offer_op(FUNC_FREE, 32'h1004);
    offer_op(FUNC_FREE, 32'h1030);
    offer_op(FUNC_FREE, 32'h1010);
    offer_op(FUNC_FREE, 32'h1010);
    offer_op(FUNC_INIT, 32'h0);
    offer_op(FUNC_FREE, 32'h1000);

    // Block size not a word multiple
    settle();
    apply_settings(32'h1000, 16'd6, 9'd3);
    offer_op(FUNC_INIT, 32'h0);
    offer_op(FUNC_ALLOC, 32'h0);

    // Buffer end lands exactly on the top of the address space
    settle();
    apply_settings(32'hFFFF_FFF0, 16'd16, 9'd1);
    offer_op(FUNC_INIT, 32'h0);

    // Ends one word short of the top: fits, list built lazily
    settle();
    apply_settings(32'hFFFF_FFEC, 16'd16, 9'd1);
    offer_op(FUNC_ALLOC, 32'h0);
    offer_op(FUNC_ALLOC, 32'h0);
    offer_op(FUNC_FREE, 32'hFFFF_FFEC);

    // Change the layout without initializing: old list, new addresses
    settle();
    apply_settings(32'hFF00_03FC, 16'hFFFC, 9'd256);
    offer_op(FUNC_ALLOC, 32'h0);
    offer_op(FUNC_FREE, 32'hFFFF_FF00);
    offer_op(FUNC_ALLOC, 32'h0);
    offer_op(FUNC_RSVD, $urandom);

    // Random phases: new layout, usually an initialize first, then a run
    // of allocates and frees with a bias that differs per phase
    random_ops = 0;
    while (random_ops < RANDOM_OPS) begin
      pick_settings(base, size, count, bogus);
      settle();
      apply_settings(base, size, count);
      phase_len      = bogus ? $urandom_range(8, 20) : $urandom_range(40, 160);
      open_with_init = ($urandom_range(0, 9) < 7);
      case ($urandom_range(0, 2))
        0:       alloc_pct = 25;
        1:       alloc_pct = 50;
        default: alloc_pct = 80;
      endcase
      for (int n = 0; n < phase_len; n++) begin
        roll = $urandom_range(0, 99);
        if (n == 0 && open_with_init) op = FUNC_INIT;
        else if (roll < 2)            op = FUNC_INIT;
        else if (roll < 3)            op = FUNC_RSVD;
        else if (roll < 3 + alloc_pct) op = FUNC_ALLOC;
        else                          op = FUNC_FREE;
        offer_op(op, (op == FUNC_FREE) ? free_target() : $urandom);
        random_ops++;
        // Back up the result side twice while words keep coming
        if (random_ops == 300 || random_ops == 1000) holds_asked <= holds_asked + 1;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (slab_errors == 0) begin
      $display("PASS fixed_block_slab_allocator");
    end else begin
      $display("FAIL fixed_block_slab_allocator");
    end
    $finish;
  end

endmodule
